// ===== design/sap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sap_pkg: shared types and constants for the shelf atlas placer
// Word layouts, placement codes and the atlas size clamp.
// ----------------------------------------------------------------------------
package sap_pkg;

  localparam int unsigned SizeW     = 13;   // atlas size and cursor width
  localparam int unsigned DimW      = 16;   // rectangle dimension width
  localparam int unsigned AtlasW    = 16;   // atlas number width
  localparam int unsigned PosW      = 12;   // pixel position width
  localparam int unsigned SizeMax   = 4096;
  localparam int unsigned SizeReset = 1024;

  typedef enum logic [1:0] {
    PLACE_DEFAULT = 2'd0,
    PLACE_CURRENT = 2'd1,
    PLACE_OWN     = 2'd2,
    PLACE_NEW     = 2'd3
  } placement_e;

  // One input word as held in the input register
  typedef struct packed {
    logic            image_present;
    logic [DimW-1:0] rect_width;
    logic [DimW-1:0] rect_height;
  } item_t;

  // One result word as held in the output register
  typedef struct packed {
    placement_e        placement;
    logic [AtlasW-1:0] atlas_number;
    logic [PosW-1:0]   pos_x;
    logic [PosW-1:0]   pos_y;
  } result_t;

  // Effective atlas edge: zero acts as one, anything above the max is clamped
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] raw);
    logic [SizeW-1:0] s;
    if (raw > SizeW'(SizeMax)) begin
      s = SizeW'(SizeMax);
    end else if (raw == '0) begin
      s = SizeW'(1);
    end else begin
      s = raw;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== design/sap_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sap_in_stage: input register
// Captures one word from the slave side and holds it until the placement
// logic consumes it.
// ----------------------------------------------------------------------------
module sap_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire sap_pkg::item_t item_i,
  output logic                valid_o,
  input  wire logic           take_i,
  output sap_pkg::item_t      item_o
);

  logic           valid_q, valid_d;
  sap_pkg::item_t item_q;

  // Free when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// ===== design/sap_place.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sap_place: shelf placement decision and packing state
// Decides where one rectangle goes and updates the row cursor, row top,
// row height and atlas numbers when the word moves on.
// ----------------------------------------------------------------------------
module sap_place (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire sap_pkg::item_t              item_i,
  input  wire logic [sap_pkg::SizeW-1:0]   size_i,
  output sap_pkg::result_t                 result_o
);

  localparam int unsigned SumW = sap_pkg::DimW + 2;

  logic [sap_pkg::SizeW-1:0]  cursor_x_q, cursor_x_d;
  logic [sap_pkg::SizeW-1:0]  row_top_q, row_top_d;
  logic [sap_pkg::SizeW-1:0]  row_height_q, row_height_d;
  logic [sap_pkg::AtlasW-1:0] cur_atlas_q, cur_atlas_d;
  logic [sap_pkg::AtlasW-1:0] next_atlas_q, next_atlas_d;

  logic [SumW-1:0]           s_ext, w_ext, h_ext;
  logic [SumW-1:0]           cx_sum, rt_sum, nr_sum;
  logic [sap_pkg::SizeW-1:0] nr_top;
  logic                      fit_row, fit_new_row, too_big;

  // Operands widened so no sum can wrap
  assign s_ext  = SumW'(size_i);
  assign w_ext  = SumW'(item_i.rect_width);
  assign h_ext  = SumW'(item_i.rect_height);
  assign cx_sum = SumW'(cursor_x_q) + w_ext;
  assign rt_sum = SumW'(row_top_q) + h_ext;
  assign nr_top = row_top_q + row_height_q;
  assign nr_sum = SumW'(row_top_q) + SumW'(row_height_q) + h_ext;

  assign fit_row     = (w_ext <= s_ext) && (cx_sum <= s_ext) && (rt_sum <= s_ext);
  assign fit_new_row = (w_ext <= s_ext) && (nr_sum <= s_ext);
  assign too_big     = (w_ext >= s_ext) || (h_ext >= s_ext);

  // Placement decision, first matching rule wins
  always_comb begin
    cursor_x_d   = cursor_x_q;
    row_top_d    = row_top_q;
    row_height_d = row_height_q;
    cur_atlas_d  = cur_atlas_q;
    next_atlas_d = next_atlas_q;
    result_o     = '{placement: sap_pkg::PLACE_DEFAULT, atlas_number: '0,
                     pos_x: '0, pos_y: '0};
    if (item_i.image_present) begin
      priority if (fit_row) begin
        result_o.placement    = sap_pkg::PLACE_CURRENT;
        result_o.atlas_number = cur_atlas_q;
        result_o.pos_x        = cursor_x_q[sap_pkg::PosW-1:0];
        result_o.pos_y        = row_top_q[sap_pkg::PosW-1:0];
        cursor_x_d            = cx_sum[sap_pkg::SizeW-1:0];
        if (h_ext > SumW'(row_height_q)) begin
          row_height_d = item_i.rect_height[sap_pkg::SizeW-1:0];
        end
      end else if (fit_new_row) begin
        result_o.placement    = sap_pkg::PLACE_CURRENT;
        result_o.atlas_number = cur_atlas_q;
        result_o.pos_y        = nr_top[sap_pkg::PosW-1:0];
        row_top_d             = nr_top;
        cursor_x_d            = item_i.rect_width[sap_pkg::SizeW-1:0];
        row_height_d          = item_i.rect_height[sap_pkg::SizeW-1:0];
      end else if (too_big) begin
        result_o.placement    = sap_pkg::PLACE_OWN;
        result_o.atlas_number = next_atlas_q;
        next_atlas_d          = next_atlas_q + 1'b1;
      end else begin
        result_o.placement    = sap_pkg::PLACE_NEW;
        result_o.atlas_number = next_atlas_q;
        cur_atlas_d           = next_atlas_q;
        next_atlas_d          = next_atlas_q + 1'b1;
        cursor_x_d            = item_i.rect_width[sap_pkg::SizeW-1:0];
        row_top_d             = '0;
        row_height_d          = item_i.rect_height[sap_pkg::SizeW-1:0];
      end
    end
  end

  // Packing state advances only when the word moves to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= '0;
      row_top_q    <= '0;
      row_height_q <= '0;
      cur_atlas_q  <= sap_pkg::AtlasW'(1);
      next_atlas_q <= sap_pkg::AtlasW'(2);
    end else if (fire_i) begin
      cursor_x_q   <= cursor_x_d;
      row_top_q    <= row_top_d;
      row_height_q <= row_height_d;
      cur_atlas_q  <= cur_atlas_d;
      next_atlas_q <= next_atlas_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/sap_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sap_out_stage: result register
// Holds one result word until the master side takes it.
// ----------------------------------------------------------------------------
module sap_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire sap_pkg::result_t result_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output sap_pkg::result_t      result_o
);

  logic             valid_q, valid_d;
  sap_pkg::result_t result_q;

  // Can load when empty or when the held word is taken this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

// ===== design/shelf_atlas_placer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shelf_atlas_placer_top: shelf packing of rectangles into square atlases
// Slave stream in, one placement word out per rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: s_axis_tuser carries image_present, s_axis_tdata carries
//   rect_width (bits 15:0) and rect_height (bits 31:16).
//   Master side: m_axis_tuser carries the placement code, m_axis_tdata carries
//   atlas_number (15:0), pos_x (27:16) and pos_y (39:28).
//   cfg_we_i / cfg_wdata_i write the atlas edge length; write only while idle.
// Path: a word taken by the input register goes through the placement logic
//   to the result register (two register stages: input, result register).
// Throughput: one word per cycle unless the master side holds off; placement
//   decision and packing state update are combinational between the registers.
// Reset: both stages empty, cursor, row top and row height zero, current
//   atlas 1, next atlas 2, atlas size 1024.
// Stall: when the master side holds off, the result register keeps its word
//   and the input register still takes one more word; s_axis_tready drops
//   only when both are full.
// ----------------------------------------------------------------------------
module shelf_atlas_placer_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration
  input  wire logic                      cfg_we_i,
  input  wire logic [sap_pkg::SizeW-1:0] cfg_wdata_i,
  // slave side
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [31:0]               s_axis_tdata,  // rect_width, rect_height
  input  wire logic [0:0]                s_axis_tuser,  // image_present
  // master side
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // atlas_number, pos_x, pos_y
  output logic [1:0]                     m_axis_tuser   // placement
);

  logic [sap_pkg::SizeW-1:0] atlas_size_q;
  logic [sap_pkg::SizeW-1:0] size_eff;
  sap_pkg::item_t            in_item, held_item;
  sap_pkg::result_t          place_res, out_res;
  logic                      held_valid, out_free, fire;

  // Atlas size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_size_q <= sap_pkg::SizeW'(sap_pkg::SizeReset);
    end else if (cfg_we_i) begin
      atlas_size_q <= cfg_wdata_i;
    end
  end

  assign size_eff = sap_pkg::eff_size(atlas_size_q);

  // Unpack slave word
  assign in_item.image_present = s_axis_tuser[0];
  assign in_item.rect_width    = s_axis_tdata[15:0];
  assign in_item.rect_height   = s_axis_tdata[31:16];

  assign fire = held_valid && out_free;

  sap_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (out_free),
    .item_o  (held_item)
  );

  sap_place u_place (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (held_item),
    .size_i   (size_eff),
    .result_o (place_res)
  );

  sap_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (held_valid),
    .result_i (place_res),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_res)
  );

  // Pack master word
  assign m_axis_tuser = out_res.placement;
  assign m_axis_tdata = {out_res.pos_y, out_res.pos_x, out_res.atlas_number};

endmodule
`default_nettype wire

// ===== design/sap_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sap_checker: port-level checks for the shelf atlas placer
// Watches the stream ports and flags stalls and result words that break the rules.
// ----------------------------------------------------------------------------
module sap_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tready,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,
  input  wire logic [1:0]  m_axis_tuser
);

  localparam logic [1:0] PlDefault = 2'(sap_pkg::PLACE_DEFAULT);
  localparam logic [1:0] PlOwn     = 2'(sap_pkg::PLACE_OWN);
  localparam logic [1:0] PlNew     = 2'(sap_pkg::PLACE_NEW);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Input side only backs up when a result is waiting
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // Default texture: whole word zero
  a_default_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == PlDefault |-> m_axis_tdata == 40'd0)
    else $error("default placement with nonzero fields");

  // Own or new atlas: origin position
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == PlOwn || m_axis_tuser == PlNew) |->
      m_axis_tdata[39:16] == 24'd0)
    else $error("fresh atlas placement off origin");

endmodule

bind shelf_atlas_placer_top sap_checker u_sap_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
